### rtl/tcw_pkg.sv
// Shared constants, types and helpers of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned ADDR_W = $clog2(CELLS);

  // Field widths of the channels.
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned ATTR_W       = 8;
  localparam int unsigned CELL_INDEX_W = 11;
  localparam int unsigned CURSOR_COL_W = 7;
  localparam int unsigned CURSOR_ROW_W = 5;

  // Width that holds both a cell index and the cell count for comparison.
  localparam int unsigned IDX_CMP_W =
      ((ADDR_W > CELL_INDEX_W) ? ADDR_W : CELL_INDEX_W) + 1;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;

  localparam logic [ATTR_W-1:0] ATTR_BLANK = 8'h00;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } state_e;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
  } cell_t;

  // Adds an offset to a cell address modulo the screen size. When both operands
  // are below CELLS, then one conditional subtract is enough.
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] lin,
                                                  input logic [ADDR_W-1:0] base);
    logic [ADDR_W:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= (ADDR_W+1)'(CELLS)) begin
      sum = sum - (ADDR_W+1)'(CELLS);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/tcw_in_if.sv
// Input channel of the text console writer: one command per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [CHAR_W-1:0]       char_code;
  logic [CELL_INDEX_W-1:0] cell_index;

  modport source (output valid, mode, char_code, cell_index, input ready);
  modport sink   (input valid, mode, char_code, cell_index, output ready);
endinterface

`default_nettype wire

### rtl/tcw_out_if.sv
// Output channel of the text console writer: one result per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_out_if import tcw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CHAR_W-1:0]       cell_char;
  logic [ATTR_W-1:0]       cell_attr;
  logic [CURSOR_COL_W-1:0] cursor_col;
  logic [CURSOR_ROW_W-1:0] cursor_row;

  modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row, output ready);
endinterface

`default_nettype wire

### rtl/text_console_writer.sv
// Top level of the text console writer: grid memory, cursor and sweep control.
`timescale 1ns / 1ps
`default_nettype none

// Text console writer. Characters and attributes live in one synchronous
// memory of COLUMNS x ROWS cells (one cell per word, character in the high
// byte). Rows are kept as a ring: a base register says where logical row 0
// starts, so a scroll only advances the base and blanks one row instead of
// moving the whole screen. An ordinary character, tab, backspace or unused
// mode is handled in the idle state alone; a read passes the read state as
// the memory read port is registered; a newline, or a character that
// scrolls at the bottom right corner, enters the sweep state while the
// single write port blanks the new row; clear sweeps the whole grid. After
// reset the block runs a clearing pass over all COLUMNS*ROWS cells before
// it takes the first command; configuration writes are taken at any time.
// The result of each command sits in an output register, and the next
// command is taken no sooner than the cycle that result is transferred,
// once any sweep is done. The cursor in a result is the cursor after the
// command, so results of newline and clear are offered while the blanking
// still runs. The attribute register is written through
// cfg_we_i/cfg_data_i and should only change while the block is idle.

module text_console_writer import tcw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ATTR_W-1:0] cfg_data_i,
  tcw_in_if.sink                 in_i,
  tcw_out_if.source              out_o
);

  // Control and cursor state.
  state_e            state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ATTR_W-1:0] attr_q, attr_d;

  // Blanking sweep: current physical address and last address to blank.
  logic [ADDR_W-1:0] sweep_addr_q, sweep_addr_d;
  logic [ADDR_W-1:0] sweep_last_q, sweep_last_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]       out_char_q, out_char_d;
  logic [ATTR_W-1:0]       out_attr_q, out_attr_d;
  logic [CURSOR_COL_W-1:0] out_col_q, out_col_d;
  logic [CURSOR_ROW_W-1:0] out_row_q, out_row_d;
  logic                    rd_ok_q, rd_ok_d;

  // Grid memory ports.
  cell_t             mem_q [CELLS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  cell_t             mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  cell_t             rdata_q;

  logic              accept;
  logic [ADDR_W-1:0] cur_pos;
  logic [ADDR_W-1:0] row_start;
  logic              scroll;
  logic              blank_row;
  logic              clear_all;

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // Logical cell address of the cursor.
  assign cur_pos = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    base_d       = base_q;
    attr_d       = attr_q;
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    out_valid_d  = out_valid_q;
    out_char_d   = out_char_q;
    out_attr_d   = out_attr_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    rd_ok_d      = rd_ok_q;
    mem_we       = 1'b0;
    mem_waddr    = sweep_addr_q;
    mem_wdata    = '{ch: CHAR_SPACE, attr: ATTR_BLANK};
    mem_raddr    = wrap_addr(ADDR_W'(in_i.cell_index), base_q);
    row_start    = '0;
    scroll       = 1'b0;
    blank_row    = 1'b0;
    clear_all    = 1'b0;

    if (cfg_we_i) begin
      attr_d = cfg_data_i;
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_char_d = '0;
          out_attr_d = '0;
          unique case (in_i.mode)
            MODE_WRITE: begin
              priority if (in_i.char_code == CHAR_NL) begin
                col_d = '0;
                if (row_q == ROW_W'(ROWS - 1)) begin
                  scroll = 1'b1;
                end else begin
                  row_d = row_q + 1'b1;
                end
                blank_row = 1'b1;
              end else if (in_i.char_code == CHAR_BS) begin
                if (cur_pos != '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = wrap_addr(cur_pos - 1'b1, base_q);
                  mem_wdata = '{ch: CHAR_SPACE, attr: attr_q};
                end
                if (col_q == '0) begin
                  if (row_q != '0) begin
                    col_d = COL_W'(COLUMNS - 1);
                    row_d = row_q - 1'b1;
                  end
                end else begin
                  col_d = col_q - 1'b1;
                end
              end else begin
                // Tab stores a single space; every other byte is stored as is.
                mem_we    = 1'b1;
                mem_waddr = wrap_addr(cur_pos, base_q);
                mem_wdata = '{ch: (in_i.char_code == CHAR_TAB) ? CHAR_SPACE
                                                               : in_i.char_code,
                              attr: attr_q};
                if (col_q == COL_W'(COLUMNS - 1)) begin
                  col_d = '0;
                  if (row_q == ROW_W'(ROWS - 1)) begin
                    scroll    = 1'b1;
                    blank_row = 1'b1;
                  end else begin
                    row_d = row_q + 1'b1;
                  end
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            end
            MODE_READ: begin
              // The memory returns the cell at the next edge; the result is
              // loaded from there.
              rd_ok_d = IDX_CMP_W'(in_i.cell_index) < IDX_CMP_W'(CELLS);
              state_d = ST_READ;
            end
            MODE_CLEAR: begin
              col_d     = '0;
              row_d     = '0;
              base_d    = '0;
              clear_all = 1'b1;
            end
            default: begin
              // Unused mode: nothing changes, the cursor is reported as is.
            end
          endcase

          // Scrolling moves the ring base down by one row; the old top row
          // becomes the new bottom row and is blanked by the sweep.
          if (scroll) begin
            base_d = wrap_addr(ADDR_W'(COLUMNS), base_q);
          end

          // Physical start of the row the cursor ends on, for newline and scroll.
          row_start = wrap_addr(ADDR_W'(row_d) * ADDR_W'(COLUMNS), base_d);

          if (clear_all) begin
            sweep_addr_d = '0;
            sweep_last_d = ADDR_W'(CELLS - 1);
            state_d      = ST_SWEEP;
          end else if (blank_row) begin
            sweep_addr_d = row_start;
            sweep_last_d = row_start + ADDR_W'(COLUMNS - 1);
            state_d      = ST_SWEEP;
          end

          if (in_i.mode != MODE_READ) begin
            out_valid_d = 1'b1;
            out_col_d   = CURSOR_COL_W'(col_d);
            out_row_d   = CURSOR_ROW_W'(row_d);
          end
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_char_d  = rd_ok_q ? rdata_q.ch : '0;
        out_attr_d  = rd_ok_q ? rdata_q.attr : '0;
        out_col_d   = CURSOR_COL_W'(col_q);
        out_row_d   = CURSOR_ROW_W'(row_q);
        state_d     = ST_IDLE;
      end
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (sweep_addr_q == sweep_last_q) begin
          state_d = ST_IDLE;
        end else begin
          sweep_addr_d = sweep_addr_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers. Reset starts a clearing pass over the whole grid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      col_q        <= '0;
      row_q        <= '0;
      base_q       <= '0;
      attr_q       <= ATTR_RESET;
      sweep_addr_q <= '0;
      sweep_last_q <= ADDR_W'(CELLS - 1);
      out_valid_q  <= 1'b0;
      rd_ok_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      base_q       <= base_d;
      attr_q       <= attr_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
      out_valid_q  <= out_valid_d;
      rd_ok_q      <= rd_ok_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_attr_q <= out_attr_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
  end

  // Grid memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cell_char  = out_char_q;
  assign out_o.cell_attr  = out_attr_q;
  assign out_o.cursor_col = out_col_q;
  assign out_o.cursor_row = out_row_q;

endmodule

`default_nettype wire
